// ----- design/movem_pkg.sv -----
// types and constants shared by the movem register list converter
package movem_pkg;

  // one character of a register list
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       predecrement;
  } in_item_t;

  // finished mask and status of one list
  typedef struct packed {
    logic [15:0] register_mask;
    logic [1:0]  status;
  } out_item_t;

  // status codes
  localparam logic [1:0] STATUS_CONVERTED = 2'd0;
  localparam logic [1:0] STATUS_NATIVE    = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  // characters of the list syntax
  localparam logic [7:0] CH_DATA  = 8'h64;  // d
  localparam logic [7:0] CH_ADDR  = 8'h61;  // a
  localparam logic [7:0] CH_DASH  = 8'h2d;  // -
  localparam logic [7:0] CH_SLASH = 8'h2f;  // /
  localparam logic [7:0] CH_HASH  = 8'h23;  // #
  localparam logic [7:0] CH_ZERO  = 8'h30;  // 0

  // highest register number of each kind (a7 is not allowed)
  localparam logic [2:0] DATA_LIMIT = 3'd7;
  localparam logic [2:0] ADDR_LIMIT = 3'd6;

  // token parser phases
  typedef enum logic [5:0] {
    PH_LETTER  = 6'b000001,  // expecting register letter
    PH_DIGIT   = 6'b000010,  // expecting first digit
    PH_SEP     = 6'b000100,  // after a register: slash or dash
    PH_RLETTER = 6'b001000,  // expecting range end letter
    PH_RDIGIT  = 6'b010000,  // expecting range end digit
    PH_RSEP    = 6'b100000   // after a range: slash
  } phase_e;

  // parser state carried between items
  typedef struct packed {
    logic [15:0] mask_acc;
    phase_e      token_phase;
    logic [2:0]  range_start;
    logic        is_address_kind;
    logic        first_pending;
    logic        error_seen;
    logic        native_form;
    logic        reverse_latched;
  } parse_st_t;

endpackage

// ----- design/movem_step.sv -----
// next parser state for one character of a register list
module movem_step (
  input  movem_pkg::parse_st_t cur_i,
  input  logic [7:0]           character_i,
  input  logic                 predecrement_i,
  output movem_pkg::parse_st_t nxt_o
);

  logic [7:0] dig;
  logic [2:0] lim;
  logic       dig_ok;
  logic       run;

  // mask of registers lo..hi of one kind
  function automatic logic [15:0] span_bits(logic [2:0] lo, logic [2:0] hi, logic addr);
    logic [8:0] upper;
    logic [7:0] lower;
    logic [7:0] m;
    upper = (9'd2 << hi) - 9'd1;
    lower = (8'd1 << lo) - 8'd1;
    m = upper[7:0] & ~lower;
    return addr ? {m, 8'h00} : {8'h00, m};
  endfunction

  assign dig    = character_i - movem_pkg::CH_ZERO;
  assign lim    = cur_i.is_address_kind ? movem_pkg::ADDR_LIMIT : movem_pkg::DATA_LIMIT;
  assign dig_ok = dig <= {5'd0, lim};

  // first-character handling and token decode
  always_comb begin
    nxt_o = cur_i;
    run   = 1'b0;
    if (cur_i.first_pending) begin
      nxt_o.first_pending   = 1'b0;
      nxt_o.reverse_latched = predecrement_i;
      if (character_i == movem_pkg::CH_HASH) begin
        nxt_o.native_form = 1'b1;
      end else begin
        run = 1'b1;
      end
    end else begin
      run = !cur_i.native_form && !cur_i.error_seen;
    end

    if (run) begin
      unique case (cur_i.token_phase)
        movem_pkg::PH_LETTER: begin
          if (character_i == movem_pkg::CH_DATA || character_i == movem_pkg::CH_ADDR) begin
            nxt_o.is_address_kind = (character_i == movem_pkg::CH_ADDR);
            nxt_o.token_phase     = movem_pkg::PH_DIGIT;
          end else begin
            nxt_o.error_seen = 1'b1;
          end
        end
        movem_pkg::PH_DIGIT: begin
          if (dig_ok) begin
            nxt_o.range_start = dig[2:0];
            nxt_o.mask_acc    = cur_i.mask_acc |
                                span_bits(dig[2:0], dig[2:0], cur_i.is_address_kind);
            nxt_o.token_phase = movem_pkg::PH_SEP;
          end else begin
            nxt_o.error_seen = 1'b1;
          end
        end
        movem_pkg::PH_SEP: begin
          if (character_i == movem_pkg::CH_SLASH) begin
            nxt_o.token_phase = movem_pkg::PH_LETTER;
          end else if (character_i == movem_pkg::CH_DASH) begin
            nxt_o.token_phase = movem_pkg::PH_RLETTER;
          end else begin
            nxt_o.error_seen = 1'b1;
          end
        end
        movem_pkg::PH_RLETTER: begin
          if (character_i == (cur_i.is_address_kind ? movem_pkg::CH_ADDR
                                                    : movem_pkg::CH_DATA)) begin
            nxt_o.token_phase = movem_pkg::PH_RDIGIT;
          end else begin
            nxt_o.error_seen = 1'b1;
          end
        end
        movem_pkg::PH_RDIGIT: begin
          if (dig_ok && dig > {5'd0, cur_i.range_start}) begin
            nxt_o.mask_acc    = cur_i.mask_acc |
                                span_bits(cur_i.range_start, dig[2:0], cur_i.is_address_kind);
            nxt_o.token_phase = movem_pkg::PH_RSEP;
          end else begin
            nxt_o.error_seen = 1'b1;
          end
        end
        movem_pkg::PH_RSEP: begin
          if (character_i == movem_pkg::CH_SLASH) begin
            nxt_o.token_phase = movem_pkg::PH_LETTER;
          end else begin
            nxt_o.error_seen = 1'b1;
          end
        end
        default: begin
          nxt_o.error_seen = 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- design/movem_register_list_to_mask.sv -----
// movem register list converter: one character per item in, one mask and status per list out.
// Each character is held in an input register and is decoded there into the parser state,
// which updates when the character moves on; the item marked last loads the result register
// at the same edge. A new character is taken every cycle, and the input stalls only while a
// finished result waits in the result register and the character in the input register is
// also the last of its list. A result is presented from the result register once its last
// character has moved on from the input register.
module movem_register_list_to_mask (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  movem_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output movem_pkg::out_item_t out_item_o
);

  logic                 s1_valid_q, s1_valid_d;
  movem_pkg::in_item_t  s1_item_q;
  logic                 in_acc;
  logic                 adv;
  movem_pkg::parse_st_t st_q, st_d, st_next;
  logic                 out_valid_q, out_valid_d;
  movem_pkg::out_item_t out_item_q, result;
  logic                 bad_end;

  // stage handshake: a non-last item always moves on
  assign adv = s1_valid_q &&
               (!s1_item_q.last_char || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !adv);

  // character decode
  movem_step u_step (
    .cur_i          (st_q),
    .character_i    (s1_item_q.character),
    .predecrement_i (s1_item_q.predecrement),
    .nxt_o          (st_next)
  );

  // result of a finished list
  assign bad_end = st_next.error_seen ||
                   st_next.token_phase == movem_pkg::PH_DIGIT ||
                   st_next.token_phase == movem_pkg::PH_RLETTER ||
                   st_next.token_phase == movem_pkg::PH_RDIGIT;

  always_comb begin
    result.register_mask = 16'h0000;
    if (st_next.native_form) begin
      result.status = movem_pkg::STATUS_NATIVE;
    end else if (bad_end) begin
      result.status = movem_pkg::STATUS_MALFORMED;
    end else begin
      result.status = movem_pkg::STATUS_CONVERTED;
      for (int i = 0; i < 16; i++) begin
        result.register_mask[i] = st_next.reverse_latched ? st_next.mask_acc[15 - i]
                                                          : st_next.mask_acc[i];
      end
    end
  end

  // parser state: back to reset after the last character
  always_comb begin
    st_d = st_q;
    if (adv) begin
      if (s1_item_q.last_char) begin
        st_d = '{mask_acc: 16'h0000, token_phase: movem_pkg::PH_LETTER, range_start: 3'd0,
                 is_address_kind: 1'b0, first_pending: 1'b1, error_seen: 1'b0,
                 native_form: 1'b0, reverse_latched: 1'b0};
      end else begin
        st_d = st_next;
      end
    end
  end

  // result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && s1_item_q.last_char) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{mask_acc: 16'h0000, token_phase: movem_pkg::PH_LETTER,
                       range_start: 3'd0, is_address_kind: 1'b0, first_pending: 1'b1,
                       error_seen: 1'b0, native_form: 1'b0, reverse_latched: 1'b0};
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
    if (adv && s1_item_q.last_char) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
